// File: rtl/olar_pkg.sv
// ----------------------------------------------------------------------------
// olar_pkg
// shared types and constants for the ordered list with append and remove
// ----------------------------------------------------------------------------
package olar_pkg;

    localparam int CAPACITY  = 64;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int VALUE_W   = 32;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_DUMP   = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic load_value;
        logic take_next;
        logic take_head;
        logic capture;
        logic occupied;
    } cell_ctrl_t;

endpackage

// File: rtl/olar_cell.sv
// ----------------------------------------------------------------------------
// olar_cell
// one list slot: holds a value, compares it with a key, shifts toward the head
// ----------------------------------------------------------------------------
module olar_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  olar_pkg::cell_ctrl_t          ctrl,
    input  logic [olar_pkg::VALUE_W-1:0]  value,
    input  logic [olar_pkg::VALUE_W-1:0]  next_data,
    input  logic [olar_pkg::VALUE_W-1:0]  head_data,
    output logic [olar_pkg::VALUE_W-1:0]  data,
    output logic                          hit
);
    import olar_pkg::*;

    logic [VALUE_W-1:0] data_reg;
    logic [VALUE_W-1:0] data_next;
    logic               hit_reg;
    logic               hit_next;

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.load_value)
        begin
            data_next = value;
        end
        else if (ctrl.take_next)
        begin
            data_next = next_data;
        end
        else if (ctrl.take_head)
        begin
            data_next = head_data;
        end
    end

    always_comb
    begin
        hit_next = hit_reg;
        if (ctrl.capture)
        begin
            hit_next = ctrl.occupied && (data_reg == value);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

// File: rtl/ordered_list_append_remove.sv
// append: result registered in the cycle after accept; next accept once the output is free
// remove: compare in the accept cycle; close-up shift and result in S_MATCH when out_free
// dump: while out_free, rotates the cell chain one slot per cycle, one result per cycle,
// first via the S_DUMP state then the output register, count results in all, or one ST_EMPTY when empty
// reset: entry count and control clear at once; stored values stay undefined, no clearing pass
// ----------------------------------------------------------------------------
// ordered_list_append_remove
// bounded insertion-ordered list of 32-bit values built as a chain of cells
// ----------------------------------------------------------------------------
module ordered_list_append_remove (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [olar_pkg::S_TDATA_W-1:0]   s_tdata,   // command[1:0], value[33:2]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [olar_pkg::M_TDATA_W-1:0]   m_tdata,   // data_out[31:0], status[33:32]
    output logic                             m_tlast
);
    import olar_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_DUMP  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   dump_idx_reg, dump_idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_data_reg, out_data_next;
    status_t            out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    logic [CMD_W-1:0]   in_cmd;
    logic [VALUE_W-1:0] in_value;
    logic               out_free;
    logic               accept;
    logic               do_append;
    logic               do_remove;
    logic               apply_remove;
    logic               rotate;
    logic               dump_last;

    logic [VALUE_W-1:0]  cell_data [CAPACITY];
    logic [CAPACITY-1:0] hits;
    logic [CAPACITY-1:0] after_match;
    cell_ctrl_t          cell_ctrl [CAPACITY];

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_value = s_tdata[CMD_W+VALUE_W-1:CMD_W];
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign do_append    = accept && (in_cmd == CMD_APPEND) && (count_reg < CNT_W'(CAPACITY));
    assign do_remove    = accept && (in_cmd == CMD_REMOVE);
    assign apply_remove = (state_reg == S_MATCH) && out_free && after_match[CAPACITY-1];
    assign rotate       = (state_reg == S_DUMP) && out_free;
    assign dump_last    = (CNT_W'(dump_idx_reg) + CNT_W'(1)) == count_reg;

    // prefix or: slot at or after the first match
    always_comb
    begin
        after_match = hits;
        for (int s = 1; s < CAPACITY; s = s * 2)
        begin
            after_match = after_match | (after_match << s);
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_W-1:0] next_data;

        if (i == CAPACITY - 1)
        begin : g_tail
            assign next_data = '0;
        end
        else
        begin : g_mid
            assign next_data = cell_data[i+1];
        end

        assign cell_ctrl[i].load_value = do_append && (count_reg == CNT_W'(i));
        assign cell_ctrl[i].take_next  = (apply_remove && after_match[i])
                                         || (rotate && (CNT_W'(i + 1) < count_reg));
        assign cell_ctrl[i].take_head  = rotate && (CNT_W'(i + 1) == count_reg);
        assign cell_ctrl[i].capture    = do_remove;
        assign cell_ctrl[i].occupied   = CNT_W'(i) < count_reg;

        olar_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl[i]),
            .value     (in_value),
            .next_data (next_data),
            .head_data (cell_data[0]),
            .data      (cell_data[i]),
            .hit       (hits[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        dump_idx_next   = dump_idx_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_APPEND:
                        begin
                            out_valid_next  = 1'b1;
                            out_data_next   = '0;
                            out_last_next   = 1'b1;
                            if (do_append)
                            begin
                                count_next      = count_reg + CNT_W'(1);
                                out_status_next = ST_OK;
                            end
                            else
                            begin
                                out_status_next = ST_FULL;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            state_next = S_MATCH;
                        end
                        CMD_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next  = 1'b1;
                                out_data_next   = '0;
                                out_status_next = ST_EMPTY;
                                out_last_next   = 1'b1;
                            end
                            else
                            begin
                                dump_idx_next = '0;
                                state_next    = S_DUMP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MATCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    if (after_match[CAPACITY-1])
                    begin
                        count_next      = count_reg - CNT_W'(1);
                        out_status_next = ST_OK;
                    end
                    else
                    begin
                        out_status_next = ST_NOT_FOUND;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_data_next   = cell_data[0];
                    out_status_next = ST_OK;
                    out_last_next   = dump_last;
                    dump_idx_next   = dump_idx_reg + IDX_W'(1);
                    if (dump_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - STATUS_W){1'b0}}, out_status_reg, out_data_reg};

endmodule

// File: rtl/olar_checker.sv
// ----------------------------------------------------------------------------
// olar_assertions
// port-level checks for the ordered list, attached to the top level by bind
// ----------------------------------------------------------------------------
module olar_assertions (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [olar_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [olar_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             m_tlast
);
    import olar_pkg::*;

    logic [STATUS_W-1:0] out_status;
    logic [VALUE_W-1:0]  out_data;

    assign out_status = m_tdata[VALUE_W+STATUS_W-1:VALUE_W];
    assign out_data   = m_tdata[VALUE_W-1:0];

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // any non-element status ends its run
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status != ST_OK) |-> m_tlast)
        else $error("error status without last");

    // results with a status other than ok carry zero data
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (out_status != ST_OK) |-> (out_data == '0))
        else $error("status result with nonzero data");

    // no new transaction accepted while a run is still being emitted
    a_no_accept_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input accepted during dump");

    // padding bits stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:VALUE_W+STATUS_W] == '0))
        else $error("padding bits set");

endmodule

bind ordered_list_append_remove olar_assertions u_olar_assertions (.*);

// File: tb/olar_checker.sv
// ----------------------------------------------------------------------------
// olar_checker
// watches both stream channels of the ordered list, keeps its own copy of the
// stored values, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module olar_checker
    import olar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 m_tlast,
    output int                   mismatches,
    output int                   pending,
    output int                   results_seen,
    output int                   peak_fill,
    output int                   full_seen,
    output int                   not_found_seen,
    output int                   empty_seen
);

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        status_t            status;
        logic               last;
    } list_result_t;

    logic [VALUE_W-1:0] list_vals[$];
    list_result_t       expected_results[$];
    int                 err_count;
    int                 result_count;
    int                 max_fill;
    int                 n_full;
    int                 n_not_found;
    int                 n_empty;

    function automatic list_result_t make_result(input logic [VALUE_W-1:0] data,
                                                 input status_t st, input logic last);
        list_result_t r;
        r.data   = data;
        r.status = st;
        r.last   = last;
        return r;
    endfunction

    // updates the shadow list and queues the results one command causes
    function automatic void predict_command(input logic [CMD_W-1:0] cmd,
                                            input logic [VALUE_W-1:0] val);
        int hit;
        hit = -1;
        case (cmd)
            CMD_APPEND:
            begin
                if (list_vals.size() >= CAPACITY)
                    expected_results.push_back(make_result('0, ST_FULL, 1'b1));
                else
                begin
                    list_vals.push_back(val);
                    expected_results.push_back(make_result('0, ST_OK, 1'b1));
                end
            end
            CMD_REMOVE:
            begin
                for (int i = 0; i < list_vals.size(); i++)
                begin
                    if (hit < 0 && list_vals[i] == val)
                        hit = i;
                end
                if (hit < 0)
                    expected_results.push_back(make_result('0, ST_NOT_FOUND, 1'b1));
                else
                begin
                    list_vals.delete(hit);
                    expected_results.push_back(make_result('0, ST_OK, 1'b1));
                end
            end
            CMD_DUMP:
            begin
                if (list_vals.size() == 0)
                    expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                else
                begin
                    for (int i = 0; i < list_vals.size(); i++)
                        expected_results.push_back(make_result(list_vals[i], ST_OK,
                                                               i == list_vals.size() - 1));
                end
            end
            default: ;
        endcase
        if (list_vals.size() > max_fill)
            max_fill = list_vals.size();
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        list_result_t exp_r;
        logic [VALUE_W-1:0]  got_data;
        logic [STATUS_W-1:0] got_status;
        if (!rst_n)
        begin
            list_vals.delete();
            expected_results.delete();
            err_count      = 0;
            result_count   = 0;
            max_fill       = 0;
            n_full         = 0;
            n_not_found    = 0;
            n_empty        = 0;
            mismatches     <= 0;
            pending        <= 0;
            results_seen   <= 0;
            peak_fill      <= 0;
            full_seen      <= 0;
            not_found_seen <= 0;
            empty_seen     <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_data   = m_tdata[VALUE_W-1:0];
                got_status = m_tdata[VALUE_W+STATUS_W-1:VALUE_W];
                result_count++;
                case (got_status)
                    ST_FULL:      n_full++;
                    ST_NOT_FOUND: n_not_found++;
                    ST_EMPTY:     n_empty++;
                    default: ;
                endcase
                if (expected_results.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected transaction: data %h status %0d last %b",
                                 got_data, got_status, m_tlast);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_data !== exp_r.data || got_status !== exp_r.status ||
                        m_tlast !== exp_r.last)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: expected %h/%0d/%b got %h/%0d/%b",
                                     exp_r.data, exp_r.status, exp_r.last,
                                     got_data, got_status, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_command(s_tdata[CMD_W-1:0], s_tdata[CMD_W+VALUE_W-1:CMD_W]);
            mismatches     <= err_count;
            pending        <= expected_results.size();
            results_seen   <= result_count;
            peak_fill      <= max_fill;
            full_seen      <= n_full;
            not_found_seen <= n_not_found;
            empty_seen     <= n_empty;
        end
    end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives append, remove, dump and unused commands into the ordered list with random
// idling on both sides, requests a long output stall while filling the list to capacity,
// and reports the verdict from the checker's mismatch and pending counts
// ----------------------------------------------------------------------------
module tb_top;

    import olar_pkg::*;

    localparam logic [CMD_W-1:0] CMD_IGNORED    = 2'd3;
    localparam int               WATCHDOG_LIMIT = 3000;
    localparam int               HOLD_CYCLES    = 160;
    localparam int               TAIL_CYCLES    = 16;
    localparam int               RANDOM_ITEMS   = 125;
    localparam int               QUIET_FROM     = 85;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    int mismatches;
    int pending;
    int results_seen;
    int peak_fill;
    int full_seen;
    int not_found_seen;
    int empty_seen;

    bit                 tx_gaps_on;
    bit                 rx_gaps_on;
    bit                 hold_ask;
    bit                 hold_done;
    int                 idle_run;
    int                 n_append;
    int                 n_remove;
    int                 n_dump;
    int                 n_ignored;
    logic [VALUE_W-1:0] value_pool[8];

    ordered_list_append_remove u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    olar_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen),
        .peak_fill      (peak_fill),
        .full_seen      (full_seen),
        .not_found_seen (not_found_seen),
        .empty_seen     (empty_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // offers one command and waits for its transaction, then maybe idles
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-CMD_W-VALUE_W){1'b0}}, val, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        case (cmd)
            CMD_APPEND: n_append++;
            CMD_REMOVE: n_remove++;
            CMD_DUMP:   n_dump++;
            default:    n_ignored++;
        endcase
        if (tx_gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // mostly values from a small set so that removes find matches
    function automatic logic [VALUE_W-1:0] pick_value(input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct)
            return value_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    // receiver side: random stalls, one long hold-off on request
    initial
    begin
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_ask && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!rx_gaps_on)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_run <= 0;
        else
        begin
            idle_run <= idle_run + 1;
            if (idle_run >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int                 r;
        int                 append_pct;
        logic [CMD_W-1:0]   cmd;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        hold_ask   = 1'b0;
        n_append   = 0;
        n_remove   = 0;
        n_dump     = 0;
        n_ignored  = 0;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < 8; i++)
            value_pool[i] = $urandom();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, extremes, head and tail removal, unused command
        send_item(CMD_DUMP,    32'h0000_0000);
        send_item(CMD_REMOVE,  32'h0000_0000);
        send_item(CMD_APPEND,  32'h8000_0000);
        send_item(CMD_APPEND,  32'h7fff_ffff);
        send_item(CMD_APPEND,  32'h0000_0000);
        send_item(CMD_APPEND,  32'hffff_ffff);
        send_item(CMD_APPEND,  32'h7fff_ffff);
        send_item(CMD_DUMP,    32'hffff_ffff);
        send_item(CMD_REMOVE,  32'h8000_0000);
        send_item(CMD_REMOVE,  32'h7fff_ffff);
        send_item(CMD_REMOVE,  32'h7fff_ffff);
        send_item(CMD_REMOVE,  32'h1234_5678);
        send_item(CMD_IGNORED, 32'hffff_ffff);
        send_item(CMD_IGNORED, 32'h0000_0000);
        send_item(CMD_DUMP,    32'h5555_aaaa);
        send_item(CMD_REMOVE,  32'h0000_0000);
        send_item(CMD_REMOVE,  32'hffff_ffff);
        send_item(CMD_DUMP,    32'h0000_0000);

        // fill to capacity and past it, with one long output hold-off requested
        hold_ask = 1'b1;
        for (int i = 0; i < CAPACITY + 3; i++)
            send_item(CMD_APPEND, pick_value(70));
        send_item(CMD_DUMP, $urandom());

        // random mix, remove-heavy first so the list drains and refills
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == QUIET_FROM)
            begin
                tx_gaps_on = 1'b0;
                rx_gaps_on = 1'b0;
            end
            append_pct = (i < 60) ? 25 : 45;
            r = $urandom_range(0, 99);
            if (r < append_pct)
                cmd = CMD_APPEND;
            else if (r < 80)
                cmd = CMD_REMOVE;
            else if (r < 95)
                cmd = CMD_DUMP;
            else
                cmd = CMD_IGNORED;
            send_item(cmd, pick_value(cmd == CMD_REMOVE ? 80 : 60));
        end
        send_item(CMD_DUMP, $urandom());
        s_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("commands: %0d append, %0d remove, %0d dump, %0d unused; peak fill %0d of %0d",
                 n_append, n_remove, n_dump, n_ignored, peak_fill, CAPACITY);
        $display("results: %0d checked, %0d full, %0d not found, %0d empty, %0d mismatches",
                 results_seen, full_seen, not_found_seen, empty_seen, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
